// ----- sv/ddm_pkg.sv -----
// Shared types, constants and codes for the dive depth monitor.
package ddm_pkg;

  // Window length; averages are taken over this many pressure samples (1 to 64).
  localparam int WINDOW_LENGTH = 8;

  // ADC to hPa scaling: ((code * SCALE_MUL / SCALE_DIV) * 100 + SCALE_OFS) / 1000.
  localparam int SCALE_MUL = 540764;
  localparam int SCALE_DIV = 11829;
  localparam int SCALE_OFS = 34779;
  localparam int HECTO     = 100;
  localparam int KILO      = 1000;

  // Reset values of the configuration registers.
  localparam int SURFACE_REF_RESET = 1100;
  localparam int DIVE_THRESH_RESET = 99;

  // Datapath widths.
  localparam int W_CODE  = 10;
  localparam int W_HPA   = 13;
  localparam int W_SEC   = 16;
  localparam int W_SUM   = 19;
  localparam int W_CNT   = 6;
  localparam int W_NUM   = 30;
  localparam int W_MB    = 20;
  localparam int W_PROD  = W_NUM + W_MB;
  localparam int W_QUO   = 19;

  // Reciprocal division: q0 = (x * floor(2^K / D)) >> K is at most one short
  // as long as x < 2^K, so one compare against the remainder fixes it.
  localparam int SCALE_SHIFT = 30;
  localparam int KILO_SHIFT  = 23;
  localparam int WIN_SHIFT   = 19;
  localparam logic [W_MB-1:0] SCALE_RECIP = W_MB'((2**SCALE_SHIFT) / SCALE_DIV);
  localparam logic [W_MB-1:0] KILO_RECIP  = W_MB'((2**KILO_SHIFT) / KILO);
  localparam logic [W_MB-1:0] WIN_RECIP   = W_MB'((2**WIN_SHIFT) / WINDOW_LENGTH);

  // Request opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes.
  localparam int W_CFG_IDX = 2;
  localparam logic [W_CFG_IDX-1:0] REG_SURFACE_REF = 2'd0;
  localparam logic [W_CFG_IDX-1:0] REG_DIVE_THRESH = 2'd1;

  typedef struct packed {
    logic              opcode;
    logic [W_CODE-1:0] adc_code;
  } in_t;

  typedef struct packed {
    logic [W_HPA-1:0] pressure_hpa;
    logic [W_HPA-1:0] depth;
    logic             diving;
    logic [W_SEC-1:0] dive_seconds;
    logic [W_HPA-1:0] max_depth;
    logic [W_SEC-1:0] last_dive_seconds;
  } out_t;

  // Which constant division the shared multiplier is working on.
  typedef enum logic [1:0] {
    DIV_SCALE = 2'd0,
    DIV_KILO  = 2'd1,
    DIV_WIN   = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     tick;
    logic     mul_recip;
    logic     mul_back;
    logic     fix;
    div_sel_t div;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic window_last;
  } status_t;

endpackage

// ----- sv/ddm_datapath.sv -----
// Datapath: shared multiplier, scaling, window average and dive tracking registers.
module ddm_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ddm_pkg::cmd_t                      cmd,
  output ddm_pkg::status_t                   status,
  input  ddm_pkg::in_t                       in_data,
  input  logic                               cfg_we,
  input  logic [ddm_pkg::W_CFG_IDX-1:0]      cfg_index,
  input  logic [ddm_pkg::W_HPA-1:0]          cfg_data,
  output ddm_pkg::out_t                      out_data
);

  logic [ddm_pkg::W_HPA-1:0]  thresh;
  logic [ddm_pkg::W_NUM-1:0]  num;
  logic [ddm_pkg::W_PROD-1:0] prod;
  logic [ddm_pkg::W_QUO-1:0]  quo;
  logic [ddm_pkg::W_SUM-1:0]  sum;
  logic [ddm_pkg::W_CNT-1:0]  count;
  logic [ddm_pkg::W_HPA-1:0]  surf_min;
  logic [ddm_pkg::W_HPA-1:0]  avg;
  logic                       dive_flag;
  logic [ddm_pkg::W_SEC-1:0]  dive_time;
  logic [ddm_pkg::W_HPA-1:0]  deepest;
  logic [ddm_pkg::W_SEC-1:0]  prev_time;

  logic [ddm_pkg::W_MB-1:0]   recip;
  logic [ddm_pkg::W_MB-1:0]   divisor;
  logic [ddm_pkg::W_QUO-1:0]  quo_est;
  logic [ddm_pkg::W_NUM-1:0]  rem;
  logic [ddm_pkg::W_QUO-1:0]  quo_fixed;
  logic [ddm_pkg::W_SUM-1:0]  sum_next;
  logic [ddm_pkg::W_CNT:0]    count_inc;
  logic [ddm_pkg::W_HPA-1:0]  avg_fixed;
  logic [ddm_pkg::W_HPA-1:0]  depth;
  logic                       entering;
  logic                       leaving;
  logic                       flag_next;
  logic [ddm_pkg::W_SEC-1:0]  time_next;
  logic [ddm_pkg::W_HPA-1:0]  deep_base;
  logic [ddm_pkg::W_HPA-1:0]  deep_next;
  logic [ddm_pkg::W_SEC-1:0]  prev_next;

  always_comb begin
    unique case (cmd.div)
      ddm_pkg::DIV_SCALE: begin
        recip   = ddm_pkg::SCALE_RECIP;
        divisor = ddm_pkg::W_MB'(ddm_pkg::SCALE_DIV);
        quo_est = prod[ddm_pkg::SCALE_SHIFT +: ddm_pkg::W_QUO];
      end
      ddm_pkg::DIV_KILO: begin
        recip   = ddm_pkg::KILO_RECIP;
        divisor = ddm_pkg::W_MB'(ddm_pkg::KILO);
        quo_est = prod[ddm_pkg::KILO_SHIFT +: ddm_pkg::W_QUO];
      end
      ddm_pkg::DIV_WIN: begin
        recip   = ddm_pkg::WIN_RECIP;
        divisor = ddm_pkg::W_MB'(ddm_pkg::WINDOW_LENGTH);
        quo_est = prod[ddm_pkg::WIN_SHIFT +: ddm_pkg::W_QUO];
      end
      default: begin
        recip   = '0;
        divisor = '0;
        quo_est = '0;
      end
    endcase
  end

  // After the back multiply, prod holds q0 * D, which never exceeds the dividend.
  assign rem       = num - prod[ddm_pkg::W_NUM-1:0];
  assign quo_fixed = quo + ddm_pkg::W_QUO'(rem >= ddm_pkg::W_NUM'(divisor));
  assign sum_next  = sum + ddm_pkg::W_SUM'(quo_fixed[ddm_pkg::W_HPA-1:0]);
  assign count_inc = {1'b0, count} + 1'b1;
  assign status.window_last = (count_inc >= (ddm_pkg::W_CNT+1)'(ddm_pkg::WINDOW_LENGTH));
  assign avg_fixed = quo_fixed[ddm_pkg::W_HPA-1:0];

  // The surface minimum has already been lowered to the average by this point.
  assign depth     = avg - surf_min;
  assign entering  = !dive_flag && (depth > thresh);
  assign leaving   = dive_flag && (depth <= thresh);
  assign flag_next = entering ? 1'b1 : (leaving ? 1'b0 : dive_flag);
  assign time_next = entering ? '0 : dive_time;
  assign deep_base = entering ? '0 : deepest;
  assign deep_next = (flag_next && (depth > deep_base)) ? depth : deep_base;
  assign prev_next = leaving ? dive_time : prev_time;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= ddm_pkg::W_NUM'(in_data.adc_code) * ddm_pkg::W_NUM'(ddm_pkg::SCALE_MUL);
    end else if (cmd.fix && (cmd.div == ddm_pkg::DIV_SCALE)) begin
      num <= ddm_pkg::W_NUM'(quo_fixed) * ddm_pkg::W_NUM'(ddm_pkg::HECTO)
             + ddm_pkg::W_NUM'(ddm_pkg::SCALE_OFS);
    end else if (cmd.fix && (cmd.div == ddm_pkg::DIV_KILO)) begin
      num <= ddm_pkg::W_NUM'(sum_next);
    end
    if (cmd.mul_recip) begin
      prod <= {{ddm_pkg::W_MB{1'b0}}, num} * {{ddm_pkg::W_NUM{1'b0}}, recip};
    end else if (cmd.mul_back) begin
      prod <= ddm_pkg::W_PROD'(quo_est) * ddm_pkg::W_PROD'(divisor);
    end
    if (cmd.mul_back) begin
      quo <= quo_est;
    end
    if (cmd.fix && (cmd.div == ddm_pkg::DIV_WIN)) begin
      avg <= avg_fixed;
    end
    if (cmd.publish) begin
      out_data.pressure_hpa      <= avg;
      out_data.depth             <= depth;
      out_data.diving            <= flag_next;
      out_data.dive_seconds      <= time_next;
      out_data.max_depth         <= deep_next;
      out_data.last_dive_seconds <= prev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh    <= ddm_pkg::W_HPA'(ddm_pkg::DIVE_THRESH_RESET);
      sum       <= '0;
      count     <= '0;
      surf_min  <= ddm_pkg::W_HPA'(ddm_pkg::SURFACE_REF_RESET);
      dive_flag <= 1'b0;
      dive_time <= '0;
      deepest   <= '0;
      prev_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ddm_pkg::REG_SURFACE_REF: begin
            surf_min <= cfg_data;
          end
          ddm_pkg::REG_DIVE_THRESH: begin
            thresh <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (cmd.fix && (cmd.div == ddm_pkg::DIV_KILO)) begin
        if (status.window_last) begin
          sum   <= '0;
          count <= '0;
        end else begin
          sum   <= sum_next;
          count <= count_inc[ddm_pkg::W_CNT-1:0];
        end
      end
      if (cmd.fix && (cmd.div == ddm_pkg::DIV_WIN) && (avg_fixed < surf_min)) begin
        surf_min <= avg_fixed;
      end
      if (cmd.tick && dive_flag && (dive_time != '1)) begin
        dive_time <= dive_time + 1'b1;
      end
      if (cmd.publish) begin
        dive_flag <= flag_next;
        dive_time <= time_next;
        deepest   <= deep_next;
        prev_time <= prev_next;
      end
    end
  end

endmodule

// ----- sv/ddm_ctrl.sv -----
// Controller: sequences the shared multiplier steps and owns the handshakes.
module ddm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ddm_pkg::status_t  status,
  output ddm_pkg::cmd_t     cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_R1   = 11'b000_0000_0010,
    S_Q1   = 11'b000_0000_0100,
    S_F1   = 11'b000_0000_1000,
    S_R2   = 11'b000_0001_0000,
    S_Q2   = 11'b000_0010_0000,
    S_F2   = 11'b000_0100_0000,
    S_R3   = 11'b000_1000_0000,
    S_Q3   = 11'b001_0000_0000,
    S_F3   = 11'b010_0000_0000,
    S_UPD  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div    = ddm_pkg::DIV_SCALE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == ddm_pkg::OP_TICK) begin
            cmd.tick = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_R1;
          end
        end
      end
      S_R1: begin
        cmd.mul_recip = 1'b1;
        state_next    = S_Q1;
      end
      S_Q1: begin
        cmd.mul_back = 1'b1;
        state_next   = S_F1;
      end
      S_F1: begin
        cmd.fix    = 1'b1;
        state_next = S_R2;
      end
      S_R2: begin
        cmd.div       = ddm_pkg::DIV_KILO;
        cmd.mul_recip = 1'b1;
        state_next    = S_Q2;
      end
      S_Q2: begin
        cmd.div      = ddm_pkg::DIV_KILO;
        cmd.mul_back = 1'b1;
        state_next   = S_F2;
      end
      S_F2: begin
        cmd.div    = ddm_pkg::DIV_KILO;
        cmd.fix    = 1'b1;
        state_next = status.window_last ? S_R3 : S_IDLE;
      end
      S_R3: begin
        cmd.div       = ddm_pkg::DIV_WIN;
        cmd.mul_recip = 1'b1;
        state_next    = S_Q3;
      end
      S_Q3: begin
        cmd.div      = ddm_pkg::DIV_WIN;
        cmd.mul_back = 1'b1;
        state_next   = S_F3;
      end
      S_F3: begin
        cmd.div    = ddm_pkg::DIV_WIN;
        cmd.fix    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        // Hold here until the output register is free.
        if (!(out_valid && out_stall)) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/dive_depth_monitor.sv -----
// Top level of the dive depth monitor: controller, datapath and checks.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid / in_stall  | ddm_pkg::in_t (opcode, code)
//  out     | output    | out_valid / out_stall| ddm_pkg::out_t (window result)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Ticks leave the block idle. A sample runs one shared multiplier through
// scale and thousandths reciprocal divisions, a window-closing sample also
// through the window average; each is a multiply, back multiply and fix, one
// step a cycle. Reset is synchronous and needs no clearing pass. The output
// register lets a new request in while a result waits; a window-closing
// sample holds in its last step while the previous result is still stalled.
module dive_depth_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ddm_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ddm_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ddm_pkg::W_CFG_IDX-1:0] cfg_index,
  input  logic [ddm_pkg::W_HPA-1:0]     cfg_data
);

  ddm_pkg::cmd_t    cmd;
  ddm_pkg::status_t status;

  assign cfg_ready = 1'b1;

  ddm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ddm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  // Depth is measured from a minimum that never exceeds the average.
  a_depth_le_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.depth <= out_data.pressure_hpa))
    else $error("depth exceeds average pressure");

  a_max_covers_depth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.diving) |-> (out_data.max_depth >= out_data.depth))
    else $error("max depth below current depth during a dive");

  a_tick_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.opcode == ddm_pkg::OP_TICK)) |=> !in_stall)
    else $error("tick request did not finish in one cycle");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.opcode == ddm_pkg::OP_SAMPLE)) |=> in_stall)
    else $error("sample request did not start the scaling sequence");

endmodule

// ----- tb/dive_depth_monitor_tb.sv -----
// Self-checking testbench for the dive depth monitor: directed table, random traffic, predictor.
module dive_depth_monitor_tb;

  localparam int SETTLE_CYCLES = 24;
  localparam int DIVE_TICKS = 20;
  localparam logic [ddm_pkg::W_CFG_IDX-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [ddm_pkg::W_CFG_IDX-1:0] REG_SPARE_3 = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  ddm_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ddm_pkg::out_t                 out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ddm_pkg::W_CFG_IDX-1:0] cfg_index = '0;
  logic [ddm_pkg::W_HPA-1:0]     cfg_data = '0;

  dive_depth_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker state and register copies, kept in step with accepted requests.
  logic [ddm_pkg::W_HPA-1:0] dive_thresh;
  logic [ddm_pkg::W_SUM-1:0] win_sum;
  logic [ddm_pkg::W_CNT-1:0] win_count;
  logic [ddm_pkg::W_HPA-1:0] surf_min;
  logic                      in_dive;
  logic [ddm_pkg::W_SEC-1:0] dive_secs;
  logic [ddm_pkg::W_HPA-1:0] deepest;
  logic [ddm_pkg::W_SEC-1:0] last_dive_secs;

  ddm_pkg::out_t pending_windows[$];
  int   failures = 0;
  bit   in_quiet = 1'b0;
  bit   out_quiet = 1'b0;
  int   stall_left = 0;

  typedef struct packed {
    ddm_pkg::in_t  req;
    int            reps;
    logic          has_want;
    ddm_pkg::out_t want;
  } dir_row_t;

  // Surface at code 0, full-scale dive with entry, ticks inside it, and the way back up.
  localparam dir_row_t DIRECTED [5] = '{
    '{'{ddm_pkg::OP_TICK, 10'd0}, 1, 1'b0, '0},
    '{'{ddm_pkg::OP_SAMPLE, 10'd0}, ddm_pkg::WINDOW_LENGTH, 1'b1,
      '{13'd34, 13'd0, 1'b0, 16'd0, 13'd0, 16'd0}},
    '{'{ddm_pkg::OP_SAMPLE, 10'd1023}, ddm_pkg::WINDOW_LENGTH, 1'b1,
      '{13'd4711, 13'd4677, 1'b1, 16'd0, 13'd4677, 16'd0}},
    '{'{ddm_pkg::OP_TICK, 10'd1023}, 2, 1'b0, '0},
    '{'{ddm_pkg::OP_SAMPLE, 10'd0}, ddm_pkg::WINDOW_LENGTH, 1'b1,
      '{13'd34, 13'd0, 1'b0, 16'd2, 13'd4677, 16'd2}}
  };

  function automatic int pick_gap(inout bit quiet);
    int r;
    if ($urandom_range(0, 63) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit advance_tracker(input ddm_pkg::in_t req, output ddm_pkg::out_t rep);
    longint unsigned hpa;
    logic [ddm_pkg::W_HPA-1:0] avg;
    logic [ddm_pkg::W_HPA-1:0] dep;
    rep = '0;
    if (req.opcode == ddm_pkg::OP_TICK) begin
      if (in_dive && dive_secs != '1) dive_secs = dive_secs + 1'b1;
      return 1'b0;
    end
    hpa = req.adc_code;
    hpa = ((hpa * ddm_pkg::SCALE_MUL / ddm_pkg::SCALE_DIV) * ddm_pkg::HECTO
           + ddm_pkg::SCALE_OFS) / ddm_pkg::KILO;
    win_sum = ddm_pkg::W_SUM'(win_sum + ddm_pkg::W_HPA'(hpa));
    if (win_count + 1 < ddm_pkg::WINDOW_LENGTH) begin
      win_count = win_count + 1'b1;
      return 1'b0;
    end
    avg = ddm_pkg::W_HPA'(win_sum / ddm_pkg::WINDOW_LENGTH);
    win_sum = '0;
    win_count = '0;
    if (avg < surf_min) surf_min = avg;
    dep = avg - surf_min;
    if (!in_dive && dep > dive_thresh) begin
      in_dive = 1'b1;
      dive_secs = '0;
      deepest = '0;
    end else if (in_dive && dep <= dive_thresh) begin
      in_dive = 1'b0;
      last_dive_secs = dive_secs;
    end
    if (in_dive && dep > deepest) deepest = dep;
    rep.pressure_hpa = avg;
    rep.depth = dep;
    rep.diving = in_dive;
    rep.dive_seconds = dive_secs;
    rep.max_depth = deepest;
    rep.last_dive_seconds = last_dive_secs;
    return 1'b1;
  endfunction

  task automatic check_window(input ddm_pkg::out_t got);
    ddm_pkg::out_t want;
    if (pending_windows.size() == 0) begin
      $error("window result with nothing expected");
      failures++;
      return;
    end
    want = pending_windows.pop_front();
    if (got.pressure_hpa != want.pressure_hpa) begin
      $error("pressure_hpa: expected %0d, got %0d", want.pressure_hpa, got.pressure_hpa);
      failures++;
    end
    if (got.depth != want.depth) begin
      $error("depth: expected %0d, got %0d", want.depth, got.depth);
      failures++;
    end
    if (got.diving != want.diving) begin
      $error("diving: expected %0d, got %0d", want.diving, got.diving);
      failures++;
    end
    if (got.dive_seconds != want.dive_seconds) begin
      $error("dive_seconds: expected %0d, got %0d", want.dive_seconds, got.dive_seconds);
      failures++;
    end
    if (got.max_depth != want.max_depth) begin
      $error("max_depth: expected %0d, got %0d", want.max_depth, got.max_depth);
      failures++;
    end
    if (got.last_dive_seconds != want.last_dive_seconds) begin
      $error("last_dive_seconds: expected %0d, got %0d",
             want.last_dive_seconds, got.last_dive_seconds);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_window(out_data);
      if (stall_left > 0) stall_left--;
      else stall_left = pick_gap(out_quiet);
      out_stall <= (stall_left > 0);
    end
  end

  // Valid stays high across back-to-back requests; it drops only for a gap or in settle().
  task automatic send_request(input ddm_pkg::in_t req, input int gap, input bit has_want,
                              input ddm_pkg::out_t want);
    ddm_pkg::out_t rep;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    if (advance_tracker(req, rep)) pending_windows.push_back(has_want ? want : rep);
  endtask

  task automatic write_register(input logic [ddm_pkg::W_CFG_IDX-1:0] idx,
                                input logic [ddm_pkg::W_HPA-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ddm_pkg::REG_SURFACE_REF) begin
      surf_min = val;
    end else if (idx == ddm_pkg::REG_DIVE_THRESH) begin
      dive_thresh = val;
    end
    @(posedge clk);
  endtask

  // A sample that closes no window can still be in flight after the last result.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pressure follows a wandering level so windows rise above and fall back to the surface.
  task automatic run_traffic(input int n_items);
    int            done;
    int            level;
    int            code;
    int            burst;
    ddm_pkg::in_t  req;
    done = 0;
    level = $urandom_range(0, 1023);
    while (done < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        repeat (burst) begin
          req.opcode = ddm_pkg::OP_TICK;
          req.adc_code = 10'($urandom);
          done++;
          send_request(req, pick_gap(in_quiet), 1'b0, '0);
        end
      end else begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 3))
            0: level = 0;
            1: level = 1023;
            2: level = $urandom_range(0, 1023);
            default: level = level + int'($urandom_range(0, 300)) - 150;
          endcase
        end
        code = level + int'($urandom_range(0, 16)) - 8;
        if (code < 0) code = 0;
        if (code > 1023) code = 1023;
        if (level < 0) level = 0;
        if (level > 1023) level = 1023;
        req.opcode = ddm_pkg::OP_SAMPLE;
        req.adc_code = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'(code);
        done++;
        send_request(req, pick_gap(in_quiet), 1'b0, '0);
      end
    end
  endtask

  initial begin
    logic [ddm_pkg::W_HPA-1:0]     surf;
    logic [ddm_pkg::W_HPA-1:0]     thr;
    logic [ddm_pkg::W_CFG_IDX-1:0] spare;
    ddm_pkg::in_t                  req;
    dive_thresh = ddm_pkg::W_HPA'(ddm_pkg::DIVE_THRESH_RESET);
    win_sum = '0;
    win_count = '0;
    surf_min = ddm_pkg::W_HPA'(ddm_pkg::SURFACE_REF_RESET);
    in_dive = 1'b0;
    dive_secs = '0;
    deepest = '0;
    last_dive_secs = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      repeat (DIRECTED[i].reps)
        send_request(DIRECTED[i].req, pick_gap(in_quiet), DIRECTED[i].has_want,
                     DIRECTED[i].want);

    for (int p = 0; p < 7; p++) begin
      settle();
      case (p)
        0: begin surf = '0; thr = '0; end
        1: begin surf = '1; thr = '1; end
        2: begin surf = '1; thr = '0; end
        3: begin surf = '0; thr = '1; end
        default: begin
          surf = ddm_pkg::W_HPA'($urandom_range(0, 8191));
          thr = ($urandom_range(0, 3) == 0) ? ddm_pkg::W_HPA'($urandom)
                                            : ddm_pkg::W_HPA'($urandom_range(0, 800));
        end
      endcase
      spare = $urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3;
      if ($urandom_range(0, 1)) begin
        write_register(ddm_pkg::REG_SURFACE_REF, surf);
        write_register(spare, ddm_pkg::W_HPA'($urandom));
        write_register(ddm_pkg::REG_DIVE_THRESH, thr);
      end else begin
        write_register(ddm_pkg::REG_DIVE_THRESH, thr);
        write_register(spare, ddm_pkg::W_HPA'($urandom));
        write_register(ddm_pkg::REG_SURFACE_REF, surf);
      end
      run_traffic(50);
    end

    // With a zero surface and threshold every window is a dive, so the ticks between
    // the two windows count dive seconds.
    settle();
    write_register(ddm_pkg::REG_SURFACE_REF, '0);
    write_register(ddm_pkg::REG_DIVE_THRESH, '0);
    for (int k = 0; k < 2; k++) begin
      req.opcode = ddm_pkg::OP_SAMPLE;
      repeat (ddm_pkg::WINDOW_LENGTH) begin
        req.adc_code = 10'($urandom);
        send_request(req, pick_gap(in_quiet), 1'b0, '0);
      end
      if (k == 0) begin
        req.opcode = ddm_pkg::OP_TICK;
        repeat (DIVE_TICKS) begin
          req.adc_code = 10'($urandom);
          send_request(req, 0, 1'b0, '0);
        end
      end
    end
    settle();

    if (failures == 0 && pending_windows.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ddm_pkg.sv
sv/ddm_datapath.sv
sv/ddm_ctrl.sv
sv/dive_depth_monitor.sv
tb/dive_depth_monitor_tb.sv
